// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the LRU key/value cache.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define LKV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hdl/lkv_pkg.sv -----
// Package for the LRU key/value cache: field widths, codes, the control
// struct that the top level hands to each cell. No dependencies.
package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic signed [VAL_W-1:0] t_value;

    // Broadcast to every cell in the chain for the beat being processed.
    typedef struct packed {
        logic update;  // the store changes this cycle
        logic hit;     // the key is present somewhere in the chain
        logic full;    // a new key must evict the least recent entry
    } t_cell_ctrl;

endpackage

// ----- hdl/lkv_if.sv -----
// Handshake interfaces of the LRU key/value cache: request, response and
// configuration channels. Depends on lkv_pkg.
interface lkv_req_if;
    import lkv_pkg::*;
    logic   valid;
    logic   ready;
    logic   operation;
    t_key   key;
    t_value value;
    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;
    logic   valid;
    logic   ready;
    logic   found;
    t_value read_value;
    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lkv_cfg_if;
    import lkv_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lru_key_value_cache_top.sv -----
// Top level of the LRU key/value cache: a move-to-front chain of lkv_cell
// entries, capacity register and response register.
// Depends on lkv_pkg, lkv_if and lkv_cell.
//
//  channel  | modport | beat carries
//  ---------+---------+----------------------------
//  i_req    | sink    | operation, key, value
//  o_rsp    | source  | found, read_value (gets only)
//  i_cfg    | sink    | data = capacity
//
// Request beats are taken back to back while no response stalls; a get's response appears in the
// response register on the next cycle. The whole chain compare, hit select
// and shift happen in the same cycle as the beat is taken.
// A pending response that is not taken stalls the request side; a put gives
// no response. Synchronous active-low reset empties the store and sets the
// capacity to 16; there is no clearing pass.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lkv_req_if.sink       i_req,
    lkv_rsp_if.source     o_rsp,
    lkv_cfg_if.sink       i_cfg
);
    import lkv_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [OCC_W-1:0] r_occupancy;
    logic             r_out_valid;
    logic             r_found;
    t_value           r_read_value;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic             accept;
    logic             is_put;
    logic             hit;
    t_value           hit_value;
    t_value           head_value;
    t_cell_ctrl       ctrl;

    t_key   c_key   [ENTRIES];
    t_value c_value [ENTRIES];
    logic   c_valid [ENTRIES];
    logic   c_seen  [ENTRIES+1];
    t_value c_sel   [ENTRIES+1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    // A capacity of zero acts as one, and anything above the entry count
    // saturates to it.
    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_put      = (i_req.operation == OP_PUT);

    assign c_seen[0] = 1'b0;
    assign c_sel[0]  = '0;
    assign hit       = c_seen[ENTRIES];
    assign hit_value = c_sel[ENTRIES];

    assign ctrl.update = accept && (is_put || hit);
    assign ctrl.hit    = hit;
    assign ctrl.full   = CMP_W'(r_occupancy) >= eff_cap;

    // The head always takes the request key; a get hit carries the old value
    // to the front.
    assign head_value = is_put ? i_req.value : hit_value;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_key   prev_key;
        t_value prev_value;
        logic   prev_valid;

        if (g == 0) begin : g_head
            assign prev_key   = i_req.key;
            assign prev_value = head_value;
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_key   = c_key[g-1];
            assign prev_value = c_value[g-1];
            assign prev_valid = c_valid[g-1];
        end

        lkv_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (i_req.key),
            .i_prev_key   (prev_key),
            .i_prev_value (prev_value),
            .i_prev_valid (prev_valid),
            .i_seen       (c_seen[g]),
            .i_sel_value  (c_sel[g]),
            .o_key        (c_key[g]),
            .o_value      (c_value[g]),
            .o_valid      (c_valid[g]),
            .o_seen       (c_seen[g+1]),
            .o_sel_value  (c_sel[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupancy <= '0;
        end else if (accept && is_put && !hit && !ctrl.full) begin
            r_occupancy <= r_occupancy + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && !is_put) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_put) begin
            r_found      <= hit;
            r_read_value <= hit ? hit_value : MISS_VALUE;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.read_value = r_read_value;

endmodule

// ----- hdl/lkv_cell.sv -----
// One entry of the recency-ordered chain: key, value and valid bit, loaded
// from the neighbor closer to the head. Depends on lkv_pkg.
module lkv_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lkv_pkg::t_cell_ctrl i_ctrl,
    input  lkv_pkg::t_key       i_key,
    input  lkv_pkg::t_key       i_prev_key,
    input  lkv_pkg::t_value     i_prev_value,
    input  logic                i_prev_valid,
    input  logic                i_seen,
    input  lkv_pkg::t_value     i_sel_value,
    output lkv_pkg::t_key       o_key,
    output lkv_pkg::t_value     o_value,
    output logic                o_valid,
    output logic                o_seen,
    output lkv_pkg::t_value     o_sel_value
);
    import lkv_pkg::*;

    t_key   r_key;
    t_value r_value;
    logic   r_valid;
    logic   match;
    logic   load;

    assign match = r_valid && (r_key == i_key);

    // On a hit every cell up to and including the matching one moves down by
    // one. On a new key the valid prefix moves down, and the last valid entry
    // falls off the end when the store is full.
    always_comb begin
        if (i_ctrl.hit) begin
            load = i_ctrl.update && !i_seen;
        end else if (i_ctrl.full) begin
            load = i_ctrl.update && r_valid;
        end else begin
            load = i_ctrl.update && i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_valid     = r_valid;
    assign o_seen      = i_seen | match;
    assign o_sel_value = i_sel_value | (match ? r_value : t_value'('0));

endmodule

// ----- hdl/lkv_checker.sv -----
// Port-level checker for the LRU key/value cache and its bind to the top.
// Depends on lkv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkv_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_req_operation,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input logic            i_rsp_found,
    input lkv_pkg::t_value i_rsp_read_value
);
    import lkv_pkg::*;

    logic req_beat;
    assign req_beat = i_req_valid && i_req_ready;

    `LKV_ASSERT_ALWAYS(a_reset_no_rsp, i_clk, (!i_rst_n |=> !i_rsp_valid), "response valid after reset")

    `LKV_ASSERT(a_rsp_hold, i_clk, i_rst_n, ((i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_found) && $stable(i_rsp_read_value))), "stalled response changed")

    `LKV_ASSERT(a_get_rsp, i_clk, i_rst_n, ((req_beat && i_req_operation == OP_GET) |=> i_rsp_valid), "get beat gave no response")

    `LKV_ASSERT(a_put_quiet, i_clk, i_rst_n, ((req_beat && i_req_operation == OP_PUT) |=> !i_rsp_valid), "put beat gave a response")

    `LKV_ASSERT(a_miss_value, i_clk, i_rst_n, ((i_rsp_valid && !i_rsp_found) |-> (i_rsp_read_value == MISS_VALUE)), "miss response without all-ones value")

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_operation  (i_req.operation),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_found      (o_rsp.found),
    .i_rsp_read_value (o_rsp.read_value)
);
